@@ rtl/bounded_integer_set_macros.svh @@
// assertion helpers for the bounded integer set
`ifndef BOUNDED_INTEGER_SET_MACROS_SVH
`define BOUNDED_INTEGER_SET_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BIS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bounded_integer_set: same-cycle check failed");
// next-cycle implication
`define BIS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bounded_integer_set: next-cycle check failed");
`else
`define BIS_ASSERT_IMP(lbl, ante, cons)
`define BIS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/bis_pkg.sv @@
`timescale 1ns / 1ps

package bis_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int VAL_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BOUNDS  = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [7:0] REG_LOWER = 8'd0;
    localparam logic [7:0] REG_UPPER = 8'd1;

    localparam logic signed [VAL_W-1:0] LOWER_RST = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] UPPER_RST = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        FSM_IDLE  = 4'b0001,
        FSM_SCAN  = 4'b0010,
        FSM_WRITE = 4'b0100,
        FSM_DONE  = 4'b1000
    } fsm_t;

endpackage

@@ rtl/bounded_integer_set.sv @@
`timescale 1ns / 1ps
// Set of distinct signed 32-bit integers held in a single-port entry memory of
// CAPACITY words, slots 0 to count-1 in use. Each word inserts (tuser 0), removes
// (tuser 1) or looks up (tuser 2 or 3) the value in tdata and returns one result
// word with status, prior membership, count, and the minimum and maximum of the set
// after the operation. For each item the memory is read one entry per cycle over
// the count stored entries to find the value, the last entry and the minimum and
// maximum; the scan then closes, the write state writes back and the done state
// loads the result. The next input word is taken only once the result of the item
// before it is loaded into the output register. A result waiting on m_tready does
// not block the next input word; the item after it holds in its last state until
// the output register frees. Bounds are written through the cfg port (index 0
// lower, 1 upper, others ignored); the user must write them only while the block
// is idle, as the block itself does not enforce it.
`include "bounded_integer_set_macros.svh"

module bounded_integer_set #(
    parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value[31:0]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // member[0], count[7:1], has_elements[8], smallest[40:9], largest[72:41], zero
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,    // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    bis_pkg::fsm_t state_reg, state_next;

    logic signed [31:0] lower_reg, upper_reg;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [1:0]         kind_reg;
    logic signed [31:0] value_reg;

    logic [CNT_W-1:0]   iss_reg;
    logic               dat_vld_reg;
    logic [ADDR_W-1:0]  dat_idx_reg;
    logic [31:0]        rd_data_reg;

    logic               found_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [31:0]        last_reg;
    logic               have_reg;
    logic signed [31:0] min_reg, max_reg;

    logic [1:0]         res_status_reg;
    logic               res_has_reg;
    logic signed [31:0] res_lo_reg, res_hi_reg;

    logic               m_valid_reg;
    logic [79:0]        m_data_reg;
    logic [1:0]         m_user_reg;

    logic [31:0]        entries_mem [CAPACITY];

    logic               rd_en, wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [31:0]        wr_data;
    logic               scan_end, out_free, in_acc;

    assign s_tready  = (state_reg == bis_pkg::FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign rd_en    = (state_reg == bis_pkg::FSM_SCAN) && (iss_reg < fill_reg);
    assign scan_end = (state_reg == bis_pkg::FSM_SCAN) && !rd_en && !dat_vld_reg;

    // the entry memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entries_mem[iss_reg[ADDR_W-1:0]];
        end
    end

    // operation outcome, evaluated in the write state
    logic               is_ins, is_rem, out_bnd, ins_ok, rem_ok, in_final;
    logic [1:0]         status_c;
    logic signed [31:0] lo_c, hi_c;
    logic               has_c;

    always_comb begin
        is_ins  = (kind_reg == bis_pkg::KIND_INSERT);
        is_rem  = (kind_reg == bis_pkg::KIND_REMOVE);
        out_bnd = (value_reg < lower_reg) || (upper_reg < value_reg);
        ins_ok  = 1'b0;
        rem_ok  = 1'b0;
        status_c = bis_pkg::ST_OK;
        if (is_ins && !found_reg) begin
            if (out_bnd) begin
                status_c = bis_pkg::ST_BOUNDS;
            end else if (fill_reg >= CNT_W'(CAPACITY)) begin
                status_c = bis_pkg::ST_FULL;
            end else begin
                ins_ok = 1'b1;
            end
        end else if (is_rem) begin
            if (found_reg) begin
                rem_ok = 1'b1;
            end else begin
                status_c = bis_pkg::ST_ABSENT;
            end
        end
        // min and max of the old set without the value, plus the value if it stays
        in_final = (found_reg && !is_rem) || ins_ok;
        lo_c  = min_reg;
        hi_c  = max_reg;
        has_c = have_reg || in_final;
        if (in_final) begin
            if (!have_reg || value_reg < min_reg) lo_c = value_reg;
            if (!have_reg || max_reg < value_reg) hi_c = value_reg;
        end
        if (!has_c) begin
            lo_c = '0;
            hi_c = '0;
        end

        fill_next = fill_reg;
        wr_en     = 1'b0;
        wr_addr   = fill_reg[ADDR_W-1:0];
        wr_data   = value_reg;
        if (state_reg == bis_pkg::FSM_WRITE) begin
            if (ins_ok) begin
                wr_en     = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
            end else if (rem_ok) begin
                // move the last entry into the hole
                wr_en     = 1'b1;
                wr_addr   = pos_reg;
                wr_data   = last_reg;
                fill_next = fill_reg - CNT_W'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bis_pkg::FSM_IDLE:  if (in_acc) state_next = bis_pkg::FSM_SCAN;
            bis_pkg::FSM_SCAN:  if (scan_end) state_next = bis_pkg::FSM_WRITE;
            bis_pkg::FSM_WRITE: state_next = bis_pkg::FSM_DONE;
            bis_pkg::FSM_DONE:  if (out_free) state_next = bis_pkg::FSM_IDLE;
            default:            state_next = bis_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bis_pkg::FSM_IDLE;
            fill_reg    <= '0;
            lower_reg   <= bis_pkg::LOWER_RST;
            upper_reg   <= bis_pkg::UPPER_RST;
            dat_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dat_vld_reg <= rd_en;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bis_pkg::REG_LOWER: lower_reg <= cfg_data;
                    bis_pkg::REG_UPPER: upper_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == bis_pkg::FSM_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg  <= s_tuser;
            value_reg <= s_tdata;
            iss_reg   <= '0;
            found_reg <= 1'b0;
            have_reg  <= 1'b0;
            pos_reg   <= '0;
            last_reg  <= '0;
        end
        if (rd_en) begin
            iss_reg     <= iss_reg + CNT_W'(1);
            dat_idx_reg <= iss_reg[ADDR_W-1:0];
        end
        if (dat_vld_reg) begin
            if (rd_data_reg == value_reg) begin
                found_reg <= 1'b1;
                pos_reg   <= dat_idx_reg;
            end else begin
                have_reg <= 1'b1;
                if (!have_reg || $signed(rd_data_reg) < min_reg) min_reg <= rd_data_reg;
                if (!have_reg || max_reg < $signed(rd_data_reg)) max_reg <= rd_data_reg;
            end
            if (CNT_W'(dat_idx_reg) == fill_reg - CNT_W'(1)) begin
                last_reg <= rd_data_reg;
            end
        end
        if (state_reg == bis_pkg::FSM_WRITE) begin
            res_status_reg <= status_c;
            res_has_reg    <= has_c;
            res_lo_reg     <= lo_c;
            res_hi_reg     <= hi_c;
        end
        if (state_reg == bis_pkg::FSM_DONE && out_free) begin
            m_user_reg <= res_status_reg;
            m_data_reg <= {7'd0, res_hi_reg, res_lo_reg, res_has_reg,
                           bis_pkg::COUNT_W'(fill_reg), found_reg};
        end
    end

    `BIS_ASSERT_IMP(a_fill_cap, 1'b1, fill_reg <= CNT_W'(CAPACITY))
    `BIS_ASSERT_NXT(a_fill_only_on_write, state_reg != bis_pkg::FSM_WRITE, $stable(fill_reg))
    `BIS_ASSERT_NXT(a_remove_drops_one, state_reg == bis_pkg::FSM_WRITE && rem_ok, fill_reg == $past(fill_reg) - CNT_W'(1))
    `BIS_ASSERT_NXT(a_result_loaded, state_reg == bis_pkg::FSM_DONE && out_free, m_valid_reg && state_reg == bis_pkg::FSM_IDLE)

endmodule

@@ sim/tb_bounded_integer_set.sv @@
`timescale 1ns / 1ps

// shadow copy of the set: tracks contents and bounds, queues the replies it predicts
class set_shadow;
    typedef struct {
        logic [1:0]                       status;
        logic                             member;
        logic [bis_pkg::COUNT_W-1:0]      count;
        logic                             has_elements;
        logic signed [bis_pkg::VAL_W-1:0] smallest;
        logic signed [bis_pkg::VAL_W-1:0] largest;
    } reply_t;

    logic signed [bis_pkg::VAL_W-1:0] lower;
    logic signed [bis_pkg::VAL_W-1:0] upper;
    logic signed [bis_pkg::VAL_W-1:0] slots [bis_pkg::CAPACITY_DEF];
    int                               fill;
    reply_t                           replies_due[$];
    int                               errors;
    int                               kind_tally[4];
    int                               status_tally[4];
    int                               peak_fill;
    int                               reg_writes;

    function new();
        lower = bis_pkg::LOWER_RST;
        upper = bis_pkg::UPPER_RST;
    endfunction

    function void write_bound(input logic [7:0] index, input logic [31:0] data);
        reg_writes++;
        if (index == bis_pkg::REG_LOWER)
            lower = data;
        else if (index == bis_pkg::REG_UPPER)
            upper = data;
    endfunction

    function void note_item(input logic [1:0] kind,
                            input logic signed [bis_pkg::VAL_W-1:0] value);
        reply_t r;
        bit     present;
        int     pos;
        present = 0;
        pos = 0;
        for (int i = 0; i < fill; i++) begin
            if (!present && slots[i] == value) begin
                present = 1;
                pos = i;
            end
        end
        r.status = bis_pkg::ST_OK;
        case (kind)
            bis_pkg::KIND_INSERT: begin
                // presence wins over bounds, bounds over capacity
                if (!present) begin
                    if (value < lower || value > upper)
                        r.status = bis_pkg::ST_BOUNDS;
                    else if (fill >= bis_pkg::CAPACITY_DEF)
                        r.status = bis_pkg::ST_FULL;
                    else begin
                        slots[fill] = value;
                        fill++;
                    end
                end
            end
            bis_pkg::KIND_REMOVE: begin
                if (!present)
                    r.status = bis_pkg::ST_ABSENT;
                else begin
                    fill--;
                    slots[pos] = slots[fill];
                end
            end
            default: ;
        endcase
        r.member = present;
        r.count = bis_pkg::COUNT_W'(fill);
        r.has_elements = (fill > 0);
        r.smallest = 0;
        r.largest = 0;
        if (fill > 0) begin
            r.smallest = slots[0];
            r.largest = slots[0];
            for (int i = 1; i < fill; i++) begin
                if (slots[i] < r.smallest)
                    r.smallest = slots[i];
                if (slots[i] > r.largest)
                    r.largest = slots[i];
            end
        end
        if (fill > peak_fill)
            peak_fill = fill;
        kind_tally[kind]++;
        replies_due.push_back(r);
    endfunction

    function void check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_result(input logic [79:0] word, input logic [1:0] status);
        reply_t r;
        if (replies_due.size() == 0) begin
            $error("result word with nothing expected: status %0d, tdata %h", status, word);
            errors++;
            return;
        end
        r = replies_due.pop_front();
        status_tally[r.status]++;
        check_field("status", r.status, status);
        check_field("member", r.member, word[0]);
        check_field("count", r.count, word[7:1]);
        check_field("has_elements", r.has_elements, word[8]);
        check_field("smallest", r.smallest, $signed(word[40:9]));
        check_field("largest", r.largest, $signed(word[72:41]));
        check_field("padding", 0, word[79:73]);
    endfunction
endclass

module tb_bounded_integer_set;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [7:0] REG_SPARE_LO = 8'd2;
    localparam logic [7:0] REG_SPARE_HI = 8'hFF;
    localparam int         HOLD_CYCLES  = 800;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         SEG_ITEMS    = 98;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    set_shadow shadow;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 0;
    bit        hold_done = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    bounded_integer_set dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no word moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // leaves tvalid high so back-to-back words need no extra edge
    task automatic send_item(input logic [1:0] kind, input logic [31:0] value);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        shadow.note_item(kind, value);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shadow.replies_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        shadow.write_bound(index, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_bounds(input logic signed [31:0] lo, input logic signed [31:0] hi);
        drain();
        write_reg(bis_pkg::REG_LOWER, lo);
        write_reg(bis_pkg::REG_UPPER, hi);
    endtask

    // first half leans toward inserts, second half toward removes
    task automatic run_segment(input int n, input logic signed [31:0] base);
        logic [1:0]         kind;
        logic signed [31:0] value;
        int                 roll;
        int                 grow;
        for (int i = 0; i < n; i++) begin
            grow = (i < n / 2) ? 60 : 20;
            roll = $urandom_range(0, 99);
            if (roll < grow)
                kind = bis_pkg::KIND_INSERT;
            else if (roll < 80)
                kind = bis_pkg::KIND_REMOVE;
            else if (roll < 95)
                kind = bis_pkg::KIND_LOOKUP;
            else
                kind = KIND_SPARE;
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                value = base + $urandom_range(0, 95);
            end else if (roll < 83) begin
                case ($urandom_range(0, 3))
                    0: value = shadow.lower;
                    1: value = shadow.upper;
                    2: value = shadow.lower - 1;
                    default: value = shadow.upper + 1;
                endcase
            end else if (roll < 91) begin
                value = $urandom;
            end else begin
                case ($urandom_range(0, 3))
                    0: value = bis_pkg::LOWER_RST;
                    1: value = bis_pkg::UPPER_RST;
                    2: value = 0;
                    default: value = -1;
                endcase
            end
            send_item(kind, value);
        end
    endtask

    initial begin
        logic signed [31:0] base;
        logic signed [31:0] seg_lo [8];
        logic signed [31:0] seg_hi [8];
        shadow = new();
        base = $urandom_range(0, 4000);
        base = base - 2000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty set, reset bounds
        send_item(bis_pkg::KIND_LOOKUP, 0);
        send_item(bis_pkg::KIND_REMOVE, 5);
        send_item(bis_pkg::KIND_INSERT, 32'h8000_0000);
        send_item(bis_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        send_item(bis_pkg::KIND_INSERT, 32'h8000_0000);
        send_item(KIND_SPARE, 32'h7FFF_FFFF);
        send_item(bis_pkg::KIND_INSERT, 0);
        send_item(bis_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        send_item(bis_pkg::KIND_INSERT, 32'h5555_5555);
        send_item(bis_pkg::KIND_INSERT, 32'hAAAA_AAAA);
        send_item(bis_pkg::KIND_REMOVE, 32'h8000_0000);
        send_item(bis_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
        send_item(bis_pkg::KIND_LOOKUP, 32'h5555_5555);

        // narrow range: present values outside it still insert silently
        set_bounds(-10, 10);
        send_item(bis_pkg::KIND_INSERT, -11);
        send_item(bis_pkg::KIND_INSERT, 11);
        send_item(bis_pkg::KIND_INSERT, -10);
        send_item(bis_pkg::KIND_INSERT, 10);
        send_item(bis_pkg::KIND_INSERT, 32'hAAAA_AAAA);
        send_item(bis_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        send_item(bis_pkg::KIND_REMOVE, -10);
        send_item(bis_pkg::KIND_REMOVE, 12345);

        // upper below lower refuses every absent insert; spare indexes are ignored
        set_bounds(1, 0);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        send_item(bis_pkg::KIND_INSERT, 0);
        send_item(bis_pkg::KIND_INSERT, 7);

        seg_lo = '{bis_pkg::LOWER_RST, base + 20, base + 30, base + 60,
                   bis_pkg::LOWER_RST, base + 50, bis_pkg::LOWER_RST, base};
        seg_hi = '{bis_pkg::UPPER_RST, base + 60, base + 30, base + 20,
                   base + 40, bis_pkg::UPPER_RST, bis_pkg::UPPER_RST, base + 95};
        for (int seg = 0; seg < 8; seg++) begin
            set_bounds(seg_lo[seg], seg_hi[seg]);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (seg == 0)
                hold_req = 1;
            // whole pool in one sweep: store fills, then refuses as full
            if (seg == 6) begin
                for (int i = 0; i < 96; i++)
                    send_item(bis_pkg::KIND_INSERT, base + i);
            end
            run_segment(SEG_ITEMS, base);
        end

        drain();
        repeat (100) @(posedge aclk);
        $display("covered %0d inserts, %0d removes, %0d lookups, %0d spare-kind words",
                 shadow.kind_tally[bis_pkg::KIND_INSERT],
                 shadow.kind_tally[bis_pkg::KIND_REMOVE],
                 shadow.kind_tally[bis_pkg::KIND_LOOKUP], shadow.kind_tally[KIND_SPARE]);
        $display("%0d reg writes, peak count %0d; status %0d ok, %0d bounds, %0d absent, %0d full",
                 shadow.reg_writes, shadow.peak_fill,
                 shadow.status_tally[bis_pkg::ST_OK], shadow.status_tally[bis_pkg::ST_BOUNDS],
                 shadow.status_tally[bis_pkg::ST_ABSENT], shadow.status_tally[bis_pkg::ST_FULL]);
        if (shadow.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
